>>> rtl/core/fdht_pkg.sv
package fdht_pkg;

  // Default sizes
  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned KEY_BYTES_DEF     = 6;

  // Fixed field widths
  localparam int unsigned KEY_W       = 48;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned SLOT_OUT_W  = 8;
  localparam int unsigned PROBE_OUT_W = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // 32-bit FNV-1a
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // Probe step multiplier
  localparam logic [3:0] PROBE_MULT = 4'd13;

  typedef enum logic [STATUS_W-1:0] {
    STAT_NEW    = 2'd0,
    STAT_REPEAT = 2'd1,
    STAT_FULL   = 2'd2
  } status_e;

endpackage

>>> rtl/core/fdht_hash.sv
module fdht_hash #(
  parameter int unsigned TableEntries = fdht_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned KeyBytes     = fdht_pkg::KEY_BYTES_DEF,
  localparam int unsigned SlotW       = $clog2(TableEntries)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fdht_pkg::KEY_W-1:0] key_i,
  output logic                       done_o,
  output logic [SlotW-1:0]           slot_o
);
  import fdht_pkg::*;

  localparam int unsigned    KeyShift = 64 - 8 * KeyBytes;
  localparam logic [2:0]     MixLast  = 3'(KeyBytes - 1);
  localparam logic [2:0]     ModLast  = 3'd7;
  localparam logic [SlotW:0] NExt     = (SlotW + 1)'(TableEntries);

  typedef enum logic [1:0] {
    H_IDLE,
    H_MIX,
    H_MOD
  } hstate_e;

  hstate_e           state_q;
  logic [2:0]        step_q;
  logic [31:0]       h_q;
  logic [63:0]       bytes_q;
  logic [SlotW-1:0]  rem_q;
  logic              done_q;

  logic [63:0]       key_ext;
  logic [31:0]       mixed;
  logic [31:0]       h_mul;
  logic [SlotW-1:0]  rem_next;

  assign key_ext = 64'(key_i) << KeyShift;
  assign mixed   = h_q ^ {24'b0, bytes_q[63:56]};
  assign h_mul   = mixed * FNV_PRIME;

  // Restoring remainder, four hash bits per cycle, MSB first
  always_comb begin
    logic [SlotW:0] r;
    r = {1'b0, rem_q};
    for (int b = 3; b >= 0; b--) begin
      r = {r[SlotW-1:0], h_q[28 + b]};
      if (r >= NExt) begin
        r = r - NExt;
      end
    end
    rem_next = r[SlotW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
      h_q     <= '0;
      bytes_q <= '0;
      rem_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        H_IDLE: begin
          if (start_i) begin
            h_q     <= FNV_BASIS;
            bytes_q <= key_ext;
            step_q  <= '0;
            state_q <= H_MIX;
          end
        end
        H_MIX: begin
          h_q     <= h_mul;
          bytes_q <= bytes_q << 8;
          if (step_q == MixLast) begin
            step_q  <= '0;
            rem_q   <= '0;
            state_q <= H_MOD;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        H_MOD: begin
          rem_q <= rem_next;
          h_q   <= h_q << 4;
          if (step_q == ModLast) begin
            done_q  <= 1'b1;
            state_q <= H_IDLE;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        default: state_q <= H_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign slot_o = rem_q;

endmodule

>>> rtl/core/fdht_mem.sv
module fdht_mem #(
  parameter int unsigned TableEntries = fdht_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned SlotW       = $clog2(TableEntries)
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [SlotW-1:0]             rd_addr_i,
  output logic [fdht_pkg::COUNT_W-1:0] rd_cnt_o,
  output logic [fdht_pkg::KEY_W-1:0]   rd_key_o,
  input  logic                         cnt_we_i,
  input  logic                         key_we_i,
  input  logic [SlotW-1:0]             wr_addr_i,
  input  logic [fdht_pkg::COUNT_W-1:0] wr_cnt_i,
  input  logic [fdht_pkg::KEY_W-1:0]   wr_key_i
);
  import fdht_pkg::*;

  logic [COUNT_W-1:0] cnt_mem [TableEntries];
  logic [KEY_W-1:0]   key_mem [TableEntries];
  logic [COUNT_W-1:0] rd_cnt_q;
  logic [KEY_W-1:0]   rd_key_q;

  always_ff @(posedge clk_i) begin
    if (cnt_we_i) begin
      cnt_mem[wr_addr_i] <= wr_cnt_i;
    end
    if (key_we_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (rd_en_i) begin
      rd_cnt_q <= cnt_mem[rd_addr_i];
      rd_key_q <= key_mem[rd_addr_i];
    end
  end

  assign rd_cnt_o = rd_cnt_q;
  assign rd_key_o = rd_key_q;

endmodule

>>> rtl/core/fnv1a_dedup_hash_table_core.sv
// Channel   Direction  Handshake           Payload
// command   in         start / busy        mac_key_i
// result    out        done_o (1 cycle)    status_o, slot_index_o, probe_count_o
//
// A key goes through FNV-1a mixing (one 32x32 multiply per byte), then restoring
// remainder reduction, then a read and a check of each slot examined through
// the registered-read count/key memories.
// After reset, a clearing pass zeroes the count memory with busy high. The result
// strobe cannot be stalled; busy drops in the cycle the strobe is shown, so the
// next command may be taken right away.
module fnv1a_dedup_hash_table_core #(
  parameter int unsigned TableEntries = fdht_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned KeyBytes     = fdht_pkg::KEY_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [fdht_pkg::KEY_W-1:0]       mac_key_i,
  output logic                             done_o,
  output logic [fdht_pkg::STATUS_W-1:0]    status_o,
  output logic [fdht_pkg::SLOT_OUT_W-1:0]  slot_index_o,
  output logic [fdht_pkg::PROBE_OUT_W-1:0] probe_count_o
);
  import fdht_pkg::*;

  localparam int unsigned    SlotW   = $clog2(TableEntries);
  localparam int unsigned    PrbW    = $clog2(TableEntries + 1);
  localparam logic [SlotW:0] NExt    = (SlotW + 1)'(TableEntries);
  localparam logic [SlotW-1:0] ClrLast = SlotW'(TableEntries - 1);
  localparam logic [PrbW-1:0]  PrbLast = PrbW'(TableEntries - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK
  } state_e;

  state_e                 state_q;
  logic [SlotW-1:0]       clr_q;
  logic [KEY_W-1:0]       key_q;
  logic [SlotW-1:0]       slot_q;
  logic [PrbW-1:0]        probes_q;
  logic                   done_q;
  status_e                status_q;
  logic [SLOT_OUT_W-1:0]  slot_out_q;
  logic [PROBE_OUT_W-1:0] probe_out_q;

  logic                   hash_start;
  logic                   hash_done;
  logic [SlotW-1:0]       hash_slot;

  logic                   rd_en;
  logic [COUNT_W-1:0]     rd_cnt;
  logic [KEY_W-1:0]       rd_key;
  logic                   cnt_we;
  logic                   key_we;
  logic [SlotW-1:0]       wr_addr;
  logic [COUNT_W-1:0]     wr_cnt;

  logic                   is_empty;
  logic                   is_match;
  logic [COUNT_W-1:0]     cnt_inc;
  logic [PrbW-1:0]        probes_inc;
  logic [SlotW-1:0]       slot_next;

  // (13 * slot) mod TableEntries by shift-and-add with compare-subtract
  always_comb begin
    logic [SlotW:0] r;
    r = '0;
    for (int b = 3; b >= 0; b--) begin
      r = {r[SlotW-1:0], 1'b0};
      if (r >= NExt) begin
        r = r - NExt;
      end
      if (PROBE_MULT[b]) begin
        r = r + {1'b0, slot_q};
        if (r >= NExt) begin
          r = r - NExt;
        end
      end
    end
    slot_next = r[SlotW-1:0];
  end

  assign hash_start = (state_q == S_IDLE) && start;
  assign is_empty   = (rd_cnt == '0);
  assign is_match   = (rd_key == key_q);
  assign cnt_inc    = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_W'(1);
  assign probes_inc = probes_q + PrbW'(1);

  fdht_hash #(
    .TableEntries (TableEntries),
    .KeyBytes     (KeyBytes)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (mac_key_i),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  fdht_mem #(
    .TableEntries (TableEntries)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (slot_q),
    .rd_cnt_o  (rd_cnt),
    .rd_key_o  (rd_key),
    .cnt_we_i  (cnt_we),
    .key_we_i  (key_we),
    .wr_addr_i (wr_addr),
    .wr_cnt_i  (wr_cnt),
    .wr_key_i  (key_q)
  );

  // Memory control; writes land before the next read of the same slot
  always_comb begin
    rd_en   = 1'b0;
    cnt_we  = 1'b0;
    key_we  = 1'b0;
    wr_addr = slot_q;
    wr_cnt  = '0;
    case (state_q)
      S_CLEAR: begin
        cnt_we  = 1'b1;
        wr_addr = clr_q;
      end
      S_READ: rd_en = 1'b1;
      S_CHECK: begin
        if (is_empty) begin
          cnt_we = 1'b1;
          key_we = 1'b1;
          wr_cnt = COUNT_W'(1);
        end else if (!is_match) begin
          cnt_we = 1'b1;
          wr_cnt = cnt_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      key_q       <= '0;
      slot_q      <= '0;
      probes_q    <= '0;
      done_q      <= 1'b0;
      status_q    <= STAT_NEW;
      slot_out_q  <= '0;
      probe_out_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          if (clr_q == ClrLast) begin
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + SlotW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            key_q   <= mac_key_i;
            state_q <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            slot_q   <= hash_slot;
            probes_q <= '0;
            state_q  <= S_READ;
          end
        end
        S_READ: state_q <= S_CHECK;
        S_CHECK: begin
          if (is_empty || is_match) begin
            done_q      <= 1'b1;
            status_q    <= is_empty ? STAT_NEW : STAT_REPEAT;
            slot_out_q  <= SLOT_OUT_W'(slot_q);
            probe_out_q <= PROBE_OUT_W'(probes_q);
            state_q     <= S_IDLE;
          end else if (probes_q == PrbLast) begin
            // last attempt collided: report full, stay on this slot
            probes_q    <= probes_inc;
            done_q      <= 1'b1;
            status_q    <= STAT_FULL;
            slot_out_q  <= SLOT_OUT_W'(slot_q);
            probe_out_q <= PROBE_OUT_W'(probes_inc);
            state_q     <= S_IDLE;
          end else begin
            probes_q <= probes_inc;
            slot_q   <= slot_next;
            state_q  <= S_READ;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign slot_index_o  = slot_out_q;
  assign probe_count_o = probe_out_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_full_probes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STAT_FULL) |-> probe_count_o == PROBE_OUT_W'(TableEntries))
    else $error("full result with wrong probe count");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import fdht_pkg::*;

  localparam int unsigned SLOTS = TABLE_ENTRIES_DEF;
  localparam int RAND_ITEMS = 1600;
  localparam int TAIL_ITEMS = 200;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    status_e                status;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [PROBE_OUT_W-1:0] probes;
  } lookup_t;

  class mac_dedup_tracker;
    logic [KEY_W-1:0]   stored_keys [SLOTS];
    logic [COUNT_W-1:0] slot_counts [SLOTS];
    lookup_t            pending_lookups [$];
    int                 mismatches;

    function new();
      foreach (slot_counts[i]) begin
        slot_counts[i] = '0;
        stored_keys[i] = '0;
      end
      mismatches = 0;
    endfunction

    function logic [31:0] fnv_hash(logic [KEY_W-1:0] key);
      logic [31:0] h;
      h = FNV_BASIS;
      // Most significant byte goes in first
      for (int i = KEY_BYTES_DEF - 1; i >= 0; i--) begin
        h = (h ^ {24'h0, key[i*8 +: 8]}) * FNV_PRIME;
      end
      return h;
    endfunction

    function void note_key(logic [KEY_W-1:0] key);
      int unsigned slot;
      int unsigned probes;
      lookup_t     res;
      slot = fnv_hash(key) % SLOTS;
      probes = 0;
      res.key = key;
      res.status = STAT_FULL;
      for (int unsigned tries = 0; tries < SLOTS; tries++) begin
        if (slot_counts[slot] == '0) begin
          stored_keys[slot] = key;
          slot_counts[slot] = COUNT_W'(1);
          res.status = STAT_NEW;
          break;
        end
        if (stored_keys[slot] == key) begin
          res.status = STAT_REPEAT;
          break;
        end
        if (slot_counts[slot] != COUNT_MAX) slot_counts[slot] = slot_counts[slot] + 1'b1;
        probes++;
        if (tries + 1 < SLOTS) slot = (slot * PROBE_MULT) % SLOTS;
      end
      res.slot = SLOT_OUT_W'(slot);
      res.probes = PROBE_OUT_W'(probes);
      pending_lookups.push_back(res);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_lookup(logic [STATUS_W-1:0] st, logic [SLOT_OUT_W-1:0] sl,
                               logic [PROBE_OUT_W-1:0] pr);
      lookup_t exp;
      if (pending_lookups.size() == 0) begin
        flag($sformatf("unexpected result: status=%0d slot=%0d probes=%0d", st, sl, pr));
        return;
      end
      exp = pending_lookups.pop_front();
      if (st !== exp.status || sl !== exp.slot || pr !== exp.probes) begin
        flag($sformatf({"key %012h: expected status=%0d slot=%0d probes=%0d,",
                        " got status=%0d slot=%0d probes=%0d"},
                       exp.key, exp.status, exp.slot, exp.probes, st, sl, pr));
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [KEY_W-1:0]       mac_key = '0;
  logic                   done;
  logic [STATUS_W-1:0]    status;
  logic [SLOT_OUT_W-1:0]  slot_index;
  logic [PROBE_OUT_W-1:0] probe_count;

  mac_dedup_tracker table_model;
  logic [KEY_W-1:0] sent_keys [$];
  logic [KEY_W-1:0] zero_slot_keys [$];
  int stall_cycles = 0;

  fnv1a_dedup_hash_table_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mac_key_i    (mac_key),
    .done_o       (done),
    .status_o     (status),
    .slot_index_o (slot_index),
    .probe_count_o(probe_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && busy === 1'b0) table_model.note_key(mac_key);
      if (done === 1'b1) table_model.check_lookup(status, slot_index, probe_count);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[fnv1a_dedup_hash_table_core] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [KEY_W-1:0] find_key(int unsigned slot);
    logic [KEY_W-1:0] k;
    do begin
      k = {16'($urandom), 32'($urandom)};
    end while (table_model.fnv_hash(k) % SLOTS != slot);
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int unsigned      r;
    r = $urandom_range(0, 99);
    k = {16'($urandom), 32'($urandom)};
    if (r < 30 || sent_keys.size() == 0) begin
      return k;
    end else if (r < 62) begin
      return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
    end else if (r < 82) begin
      // Hammer slot zero so its collision count saturates
      return zero_slot_keys[$urandom_range(0, zero_slot_keys.size() - 1)];
    end else if (r < 92) begin
      k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
      return find_key(table_model.fnv_hash(k) % SLOTS);
    end
    for (int b = 0; b < KEY_W / 8; b++) begin
      case ($urandom_range(0, 2))
        0: k[b*8 +: 8] = 8'h00;
        1: k[b*8 +: 8] = 8'hFF;
        default: ;
      endcase
    end
    return k;
  endfunction

  function automatic int idle_gap(bit enable);
    if (enable && $urandom_range(0, 99) < 35) return $urandom_range(1, 16);
    return 0;
  endfunction

  task automatic send_key(logic [KEY_W-1:0] k, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    mac_key <= k;
    sent_keys.push_back(k);
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  initial begin
    logic [KEY_W-1:0] ka, kb, kc;
    logic [KEY_W-1:0] directed [$];
    bit               idling;
    table_model = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 6; i++) zero_slot_keys.push_back(find_key(0));
    ka = 48'h0123_4567_89AB;
    kb = find_key(table_model.fnv_hash(ka) % SLOTS);
    kc = find_key(table_model.fnv_hash(ka) % SLOTS);

    // Extremes, byte order, slot-zero self loop, and a short collision chain
    directed = '{48'h0, 48'h0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'h0000_0000_0001,
                 48'h0100_0000_0000, 48'h8000_0000_0000, 48'h0000_0000_0080,
                 zero_slot_keys[0], zero_slot_keys[1], zero_slot_keys[0],
                 zero_slot_keys[1], ka, kb, kc, kb, kc, ka};
    foreach (directed[i]) send_key(directed[i], idle_gap(1'b1));

    idling = 1'b1;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 64 == 0) idling = ($urandom_range(0, 1) == 1);
      send_key(pick_key(), idle_gap(idling && n < RAND_ITEMS - TAIL_ITEMS));
    end
    start <= 1'b0;
    // Let the monitor note the last accepted transaction first
    @(posedge clk_i);

    while (table_model.pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (table_model.mismatches == 0) begin
      $display("[fnv1a_dedup_hash_table_core] OK");
    end else begin
      $display("[fnv1a_dedup_hash_table_core] ERROR");
    end
    $finish;
  end

endmodule

>>> fnv1a_dedup_hash_table_core.f
rtl/core/fdht_pkg.sv
rtl/core/fdht_hash.sv
rtl/core/fdht_mem.sv
rtl/core/fnv1a_dedup_hash_table_core.sv
tb/tb.sv
